// ----- src/odcs_pkg.sv -----
`timescale 1ns / 1ps

package odcs_pkg;

    localparam int DEF_DISPLAY_WIDTH  = 96;
    localparam int DEF_DISPLAY_HEIGHT = 64;

    localparam int MAX_BYTES = 13;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // request codes
    localparam logic [2:0] CMD_LINE  = 3'd0;
    localparam logic [2:0] CMD_FRAME = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_COPY  = 3'd3;
    localparam logic [2:0] CMD_DIM   = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;

    // controller opcodes
    localparam logic [7:0] OP_LINE  = 8'h21;
    localparam logic [7:0] OP_RECT  = 8'h22;
    localparam logic [7:0] OP_COPY  = 8'h23;
    localparam logic [7:0] OP_DIM   = 8'h24;
    localparam logic [7:0] OP_CLEAR = 8'h25;
    localparam logic [7:0] OP_FILL  = 8'h26;
    localparam logic [7:0] FILL_ON  = 8'h01;

    localparam logic [CNT_W-1:0] LEN_LINE  = CNT_W'(8);
    localparam logic [CNT_W-1:0] LEN_FRAME = CNT_W'(13);
    localparam logic [CNT_W-1:0] LEN_COPY  = CNT_W'(7);
    localparam logic [CNT_W-1:0] LEN_WIN   = CNT_W'(5);

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [7:0]  x_dest;
        logic [7:0]  y_dest;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic [15:0] line_color;
        logic [15:0] fill_color;
    } req_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } frame_t;

    function automatic logic [7:0] red5(input logic [15:0] c);
        red5 = {3'b000, c[15:11]};
    endfunction

    function automatic logic [7:0] green6(input logic [15:0] c);
        green6 = {2'b00, c[10:5]};
    endfunction

    function automatic logic [7:0] blue5(input logic [15:0] c);
        blue5 = {3'b000, c[4:0]};
    endfunction

endpackage

// ----- src/odcs_encode.sv -----
`timescale 1ns / 1ps

module odcs_encode #(
    parameter int DISPLAY_WIDTH  = odcs_pkg::DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = odcs_pkg::DEF_DISPLAY_HEIGHT
) (
    input  odcs_pkg::req_t   req,
    output odcs_pkg::frame_t frame
);

    localparam logic [8:0] X_SIZE = 9'(DISPLAY_WIDTH);
    localparam logic [8:0] Y_SIZE = 9'(DISPLAY_HEIGHT);
    localparam logic [7:0] X_MAX  = 8'(DISPLAY_WIDTH - 1);
    localparam logic [7:0] Y_MAX  = 8'(DISPLAY_HEIGHT - 1);

    logic [7:0] xs_clip;
    logic [7:0] ys_clip;
    logic [7:0] xe_clip;
    logic [7:0] ye_clip;
    logic [7:0] fill_x_end;
    logic [7:0] fill_y_end;
    logic [7:0] fill_r;
    logic [7:0] fill_g;
    logic [7:0] fill_b;

    always_comb
    begin
        xs_clip = ({1'b0, req.x_start} >= X_SIZE) ? X_MAX : req.x_start;
        xe_clip = ({1'b0, req.x_end}   >= X_SIZE) ? X_MAX : req.x_end;
        ys_clip = ({1'b0, req.y_start} >= Y_SIZE) ? Y_MAX : req.y_start;
        ye_clip = ({1'b0, req.y_end}   >= Y_SIZE) ? Y_MAX : req.y_end;

        // end = start + size - 1, wraps mod 256
        fill_x_end = req.x_start + req.rect_width - 8'd1;
        fill_y_end = req.y_start + req.rect_height - 8'd1;

        // 6-bit channel scaling for the fill rectangle
        fill_r = {2'b00, req.fill_color[15:11], 1'b0};
        fill_g = {2'b00, req.fill_color[10:5]};
        fill_b = {2'b00, req.fill_color[4:0], 1'b0};
    end

    always_comb
    begin
        frame = '0;
        case (req.command)
            odcs_pkg::CMD_LINE:
            begin
                frame.bytes[0] = odcs_pkg::OP_LINE;
                frame.bytes[1] = xs_clip;
                frame.bytes[2] = ys_clip;
                frame.bytes[3] = xe_clip;
                frame.bytes[4] = ye_clip;
                frame.bytes[5] = odcs_pkg::red5(req.line_color);
                frame.bytes[6] = odcs_pkg::green6(req.line_color);
                frame.bytes[7] = odcs_pkg::blue5(req.line_color);
                frame.count    = odcs_pkg::LEN_LINE;
            end
            odcs_pkg::CMD_FRAME:
            begin
                frame.bytes[0]  = odcs_pkg::OP_FILL;
                frame.bytes[1]  = odcs_pkg::FILL_ON;
                frame.bytes[2]  = odcs_pkg::OP_RECT;
                frame.bytes[3]  = xs_clip;
                frame.bytes[4]  = ys_clip;
                frame.bytes[5]  = xe_clip;
                frame.bytes[6]  = ye_clip;
                frame.bytes[7]  = odcs_pkg::red5(req.line_color);
                frame.bytes[8]  = odcs_pkg::green6(req.line_color);
                frame.bytes[9]  = odcs_pkg::blue5(req.line_color);
                frame.bytes[10] = odcs_pkg::red5(req.fill_color);
                frame.bytes[11] = odcs_pkg::green6(req.fill_color);
                frame.bytes[12] = odcs_pkg::blue5(req.fill_color);
                frame.count     = odcs_pkg::LEN_FRAME;
            end
            odcs_pkg::CMD_FILL:
            begin
                frame.bytes[0]  = odcs_pkg::OP_FILL;
                frame.bytes[1]  = odcs_pkg::FILL_ON;
                frame.bytes[2]  = odcs_pkg::OP_RECT;
                frame.bytes[3]  = req.x_start;
                frame.bytes[4]  = req.y_start;
                frame.bytes[5]  = fill_x_end;
                frame.bytes[6]  = fill_y_end;
                frame.bytes[7]  = fill_r;
                frame.bytes[8]  = fill_g;
                frame.bytes[9]  = fill_b;
                frame.bytes[10] = fill_r;
                frame.bytes[11] = fill_g;
                frame.bytes[12] = fill_b;
                frame.count     = odcs_pkg::LEN_FRAME;
            end
            odcs_pkg::CMD_COPY:
            begin
                frame.bytes[0] = odcs_pkg::OP_COPY;
                frame.bytes[1] = req.x_start;
                frame.bytes[2] = req.y_start;
                frame.bytes[3] = req.x_end;
                frame.bytes[4] = req.y_end;
                frame.bytes[5] = req.x_dest;
                frame.bytes[6] = req.y_dest;
                frame.count    = odcs_pkg::LEN_COPY;
            end
            odcs_pkg::CMD_DIM, odcs_pkg::CMD_CLEAR:
            begin
                frame.bytes[0] = (req.command == odcs_pkg::CMD_DIM) ?
                                 odcs_pkg::OP_DIM : odcs_pkg::OP_CLEAR;
                frame.bytes[1] = req.x_start;
                frame.bytes[2] = req.y_start;
                frame.bytes[3] = req.x_end;
                frame.bytes[4] = req.y_end;
                frame.count    = odcs_pkg::LEN_WIN;
            end
            default:
            begin
                // unknown codes produce no bytes
                frame = '0;
            end
        endcase
    end

endmodule

// ----- src/odcs_shift.sv -----
`timescale 1ns / 1ps

module odcs_shift (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  odcs_pkg::frame_t load_frame,
    output logic             load_ready,
    output logic [7:0]       cmd_byte,
    output logic             last_byte,
    output logic             byte_valid,
    input  logic             byte_stall
);

    localparam int CW = odcs_pkg::CNT_W;

    logic [odcs_pkg::MAX_BYTES-1:0][7:0] bytes_reg;
    logic [odcs_pkg::MAX_BYTES-1:0][7:0] bytes_next;
    logic [CW-1:0]                       left_reg;
    logic [CW-1:0]                       left_next;
    logic                                beat;
    logic                                load;

    assign byte_valid = (left_reg != '0);
    assign last_byte  = (left_reg == CW'(1));
    assign cmd_byte   = bytes_reg[0];
    assign beat       = byte_valid && !byte_stall;

    // empty, or the final byte leaves this cycle
    assign load_ready = (left_reg == '0) || (last_byte && beat);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        bytes_next = bytes_reg;
        left_next  = left_reg;
        if (load)
        begin
            bytes_next = load_frame.bytes;
            left_next  = load_frame.count;
        end
        else if (beat)
        begin
            bytes_next = {8'h00, bytes_reg[odcs_pkg::MAX_BYTES-1:1]};
            left_next  = left_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// ----- src/oled_draw_command_serializer.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   command .. fill_color
// byte      out        byte_valid/byte_stall cmd_byte, last_byte
//
// a request emits 5, 7, 8 or 13 byte beats, one per cycle while byte_stall is low;
// the byte shift register sets the rate
// unknown codes are dropped and load no bytes into the byte shift register
// reset clears the request valid and the byte count; payload is not reset
// a stall on the byte side holds the current byte; the next request waits
// in the request register and is encoded and loaded as the last byte leaves
module oled_draw_command_serializer #(
    parameter int DISPLAY_WIDTH  = odcs_pkg::DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = odcs_pkg::DEF_DISPLAY_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  x_end,
    input  logic [7:0]  y_end,
    input  logic [7:0]  x_dest,
    input  logic [7:0]  y_dest,
    input  logic [7:0]  rect_width,
    input  logic [7:0]  rect_height,
    input  logic [15:0] line_color,
    input  logic [15:0] fill_color,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  cmd_byte,
    output logic        last_byte
);

    odcs_pkg::req_t   req_reg;
    odcs_pkg::req_t   req_next;
    logic             pend_reg;
    logic             pend_next;
    odcs_pkg::frame_t frame;
    logic             load_ready;
    logic             req_beat;

    assign req_stall = pend_reg && !load_ready;
    assign req_beat  = req_valid && !req_stall;

    always_comb
    begin
        req_next  = req_reg;
        pend_next = pend_reg && !load_ready;
        if (req_beat)
        begin
            req_next.command     = command;
            req_next.x_start     = x_start;
            req_next.y_start     = y_start;
            req_next.x_end       = x_end;
            req_next.y_end       = y_end;
            req_next.x_dest      = x_dest;
            req_next.y_dest      = y_dest;
            req_next.rect_width  = rect_width;
            req_next.rect_height = rect_height;
            req_next.line_color  = line_color;
            req_next.fill_color  = fill_color;
            pend_next            = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    odcs_encode #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_encode (
        .req   (req_reg),
        .frame (frame)
    );

    odcs_shift u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (pend_reg),
        .load_frame (frame),
        .load_ready (load_ready),
        .cmd_byte   (cmd_byte),
        .last_byte  (last_byte),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import odcs_pkg::*;

    localparam int ITEMS_PER_PHASE = 70;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } byte_beat_t;

    // known holds the typed bytes right-justified, first byte leftmost
    typedef struct packed {
        req_t         req;
        logic         typed;
        logic [3:0]   known_len;
        logic [103:0] known;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  command = '0;
    logic [7:0]  x_start = '0;
    logic [7:0]  y_start = '0;
    logic [7:0]  x_end = '0;
    logic [7:0]  y_end = '0;
    logic [7:0]  x_dest = '0;
    logic [7:0]  y_dest = '0;
    logic [7:0]  rect_width = '0;
    logic [7:0]  rect_height = '0;
    logic [15:0] line_color = '0;
    logic [15:0] fill_color = '0;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  cmd_byte;
    logic        last_byte;

    byte_beat_t  pending_bytes[$];
    stim_row_t   dir_rows[$];
    logic [7:0]  enc_buf[13];
    int          enc_len;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          holds_served;
    int          hold_left;

    oled_draw_command_serializer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .command     (command),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .x_dest      (x_dest),
        .y_dest      (y_dest),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .line_color  (line_color),
        .fill_color  (fill_color),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .cmd_byte    (cmd_byte),
        .last_byte   (last_byte)
    );

    always #4 clk = ~clk;

    function automatic req_t mk_req(input logic [2:0] cmd, input logic [7:0] xs,
                                    input logic [7:0] ys, input logic [7:0] xe,
                                    input logic [7:0] ye, input logic [7:0] xd,
                                    input logic [7:0] yd, input logic [7:0] w,
                                    input logic [7:0] h, input logic [15:0] lc,
                                    input logic [15:0] fc);
        req_t r;
        r.command     = cmd;
        r.x_start     = xs;
        r.y_start     = ys;
        r.x_end       = xe;
        r.y_end       = ye;
        r.x_dest      = xd;
        r.y_dest      = yd;
        r.rect_width  = w;
        r.rect_height = h;
        r.line_color  = lc;
        r.fill_color  = fc;
        return r;
    endfunction

    function automatic logic [7:0] clamp_coord(input logic [7:0] v, input int size);
        return (int'(v) >= size) ? 8'(size - 1) : v;
    endfunction

    function automatic void emit(input logic [7:0] b);
        enc_buf[enc_len] = b;
        enc_len++;
    endfunction

    function automatic void emit_565(input logic [15:0] c);
        emit({3'b000, c[15:11]});
        emit({2'b00, c[10:5]});
        emit({3'b000, c[4:0]});
    endfunction

    // byte run the controller should see for one request
    function automatic void encode_request(input req_t r);
        logic [7:0] xs, ys, xe, ye;
        xs = r.x_start;
        ys = r.y_start;
        xe = r.x_end;
        ye = r.y_end;
        enc_len = 0;
        if (r.command == CMD_LINE || r.command == CMD_FRAME)
        begin
            xs = clamp_coord(xs, DEF_DISPLAY_WIDTH);
            xe = clamp_coord(xe, DEF_DISPLAY_WIDTH);
            ys = clamp_coord(ys, DEF_DISPLAY_HEIGHT);
            ye = clamp_coord(ye, DEF_DISPLAY_HEIGHT);
        end
        case (r.command)
            CMD_LINE:
            begin
                emit(OP_LINE);
                emit(xs);
                emit(ys);
                emit(xe);
                emit(ye);
                emit_565(r.line_color);
            end
            CMD_FRAME:
            begin
                emit(OP_FILL);
                emit(FILL_ON);
                emit(OP_RECT);
                emit(xs);
                emit(ys);
                emit(xe);
                emit(ye);
                emit_565(r.line_color);
                emit_565(r.fill_color);
            end
            CMD_FILL:
            begin
                emit(OP_FILL);
                emit(FILL_ON);
                emit(OP_RECT);
                emit(xs);
                emit(ys);
                emit(xs + r.rect_width - 8'd1);
                emit(ys + r.rect_height - 8'd1);
                // 6-bit channels, sent twice for outline and interior
                repeat (2)
                begin
                    emit({2'b00, r.fill_color[15:11], 1'b0});
                    emit({2'b00, r.fill_color[10:5]});
                    emit({2'b00, r.fill_color[4:0], 1'b0});
                end
            end
            CMD_COPY:
            begin
                emit(OP_COPY);
                emit(xs);
                emit(ys);
                emit(xe);
                emit(ye);
                emit(r.x_dest);
                emit(r.y_dest);
            end
            CMD_DIM, CMD_CLEAR:
            begin
                emit(r.command == CMD_DIM ? OP_DIM : OP_CLEAR);
                emit(xs);
                emit(ys);
                emit(xe);
                emit(ye);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_coord(input int size);
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1: return 8'($urandom_range(size - 1));
            2: return 8'($urandom_range(size + 1, size - 2));
            default: return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_size();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic req_t random_request();
        logic [2:0] cmd;
        // unknown codes now and then, they produce no bytes
        if ($urandom_range(99) < 6)
            cmd = 3'($urandom_range(7, 6));
        else
            cmd = 3'($urandom_range(5));
        return mk_req(cmd, pick_coord(DEF_DISPLAY_WIDTH), pick_coord(DEF_DISPLAY_HEIGHT),
                      pick_coord(DEF_DISPLAY_WIDTH), pick_coord(DEF_DISPLAY_HEIGHT),
                      pick_coord(DEF_DISPLAY_WIDTH), pick_coord(DEF_DISPLAY_HEIGHT),
                      pick_size(), pick_size(), pick_color(), pick_color());
    endfunction

    task automatic send_request(input stim_row_t row);
        int i;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        command     <= row.req.command;
        x_start     <= row.req.x_start;
        y_start     <= row.req.y_start;
        x_end       <= row.req.x_end;
        y_end       <= row.req.y_end;
        x_dest      <= row.req.x_dest;
        y_dest      <= row.req.y_dest;
        rect_width  <= row.req.rect_width;
        rect_height <= row.req.rect_height;
        line_color  <= row.req.line_color;
        fill_color  <= row.req.fill_color;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        // request taken at this edge
        if (row.typed)
        begin
            enc_len = int'(row.known_len);
            for (i = 0; i < enc_len; i++)
                enc_buf[i] = row.known[8 * (enc_len - 1 - i) +: 8];
        end
        else
        begin
            encode_request(row.req);
        end
        for (i = 0; i < enc_len; i++)
            pending_bytes.push_back('{value: enc_buf[i], last: (i == enc_len - 1)});
    endtask

    // byte side stall, with a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_stall   <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (hold_left != 0)
        begin
            byte_stall <= 1'b1;
            hold_left  <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            byte_stall   <= 1'b1;
        end
        else
        begin
            byte_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_beat
        byte_beat_t want;
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("cmd_byte: expected none, got %h", cmd_byte);
                mismatch_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (cmd_byte !== want.value)
                begin
                    $error("cmd_byte: expected %h, got %h", want.value, cmd_byte);
                    mismatch_count++;
                end
                if (last_byte !== want.last)
                begin
                    $error("last_byte: expected %b, got %b", want.last, last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        int phase;
        int n_valid;
        stim_row_t row;

        phase_idle  = '{0, 77, 0, 20};
        phase_stall = '{0, 0, 77, 20};

        // typed rows: window ops at extremes, clamped line, unknown codes, empty fill
        dir_rows.push_back({mk_req(CMD_DIM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000),
                            1'b1, 4'd5, 104'({OP_DIM, 32'h0})});
        dir_rows.push_back({mk_req(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
                            1'b1, 4'd5, 104'({OP_CLEAR, 32'hFFFF_FFFF})});
        dir_rows.push_back({mk_req(CMD_COPY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
                            1'b1, 4'd7, 104'({OP_COPY, 48'hFFFF_FFFF_FFFF})});
        dir_rows.push_back({mk_req(CMD_COPY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000),
                            1'b1, 4'd7, 104'({OP_COPY, 48'h0})});
        dir_rows.push_back({mk_req(3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
                            1'b1, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000),
                            1'b1, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_LINE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
                            1'b1, 4'd8,
                            104'({OP_LINE, 8'h5F, 8'h3F, 8'h5F, 8'h3F, 8'h1F, 8'h3F, 8'h1F})});
        dir_rows.push_back({mk_req(CMD_LINE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000),
                            1'b1, 4'd8, 104'({OP_LINE, 56'h0})});
        dir_rows.push_back({mk_req(CMD_FILL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000),
                            1'b1, 4'd13,
                            104'({OP_FILL, FILL_ON, OP_RECT, 8'h00, 8'h00, 8'hFF, 8'hFF, 48'h0})});
        // predicted rows: clamp boundaries, wraps, channel patterns
        dir_rows.push_back({mk_req(CMD_LINE, 8'd95, 8'd63, 8'd96, 8'd64, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'hF800, 16'h0000), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_LINE, 8'h80, 8'h40, 8'h7F, 8'h3F, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h5555, 16'hAAAA), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 16'hFFFF, 16'h0000), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_FRAME, 8'd96, 8'd64, 8'd95, 8'd63, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h07E0, 16'h001F), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_FRAME, 8'h0A, 8'h05, 8'h50, 8'h30, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'hAAAA, 16'h5555), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_FILL, 8'd10, 8'd20, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h01, 8'h01, 16'h0000, 16'hA5A5), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_FILL, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 8'd200, 16'h0000, 16'h5A5A), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_DIM, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_CLEAR, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h00, 8'h00,
                                   8'h00, 8'h00, 16'h0000, 16'h0000), 1'b0, 4'd0, 104'h0});
        dir_rows.push_back({mk_req(CMD_COPY, 8'h01, 8'h02, 8'h5F, 8'h3F, 8'h80, 8'h01,
                                   8'h00, 8'h00, 16'h0000, 16'h0000), 1'b0, 4'd0, 104'h0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i]);

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = phase_idle[phase];
            stall_pct = phase_stall[phase];
            // sender keeps offering through a long byte side hold-off
            if (phase == 0)
                hold_requests++;
            n_valid = 0;
            while (n_valid < ITEMS_PER_PHASE)
            begin
                row = {random_request(), 1'b0, 4'd0, 104'h0};
                send_request(row);
                if (row.req.command <= CMD_CLEAR)
                    n_valid++;
            end
        end
        req_valid <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- oled_draw_command_serializer.f -----
src/odcs_pkg.sv
src/odcs_encode.sv
src/odcs_shift.sv
src/oled_draw_command_serializer.sv
sim/tb_top.sv
